>>> hdl/cmbe_pkg.sv
// Shared types and constants for the combination enumerator.
package cmbe_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned SLOT_W    = 4;
	localparam int unsigned ORD_W     = 49;
	localparam int unsigned COUNT_N_W = 7;
	localparam int unsigned COUNT_R_W = 5;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 7;
	localparam int unsigned S_DATA_W  = 40;
	localparam int unsigned M_DATA_W  = 88;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_NEXT = 1'b1
	} cmbe_func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_N = 1'b0,
		REG_COUNT_R = 1'b1
	} cmbe_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_FILL,
		ST_COUNT,
		ST_READ,
		ST_CAP,
		ST_SEND
	} cmbe_state_t;

	// Commands from the input side to the sequencer.
	typedef struct packed {
		logic restart;
		logic next;
	} cmbe_cmd_t;

	// One result transaction.
	typedef struct packed {
		logic signed [VALUE_W-1:0] element_value;
		logic [SLOT_W-1:0]         slot;
		logic [ORD_W-1:0]          ordinal;
		logic                      last;
		logic                      exhausted;
	} cmbe_res_t;

	localparam cmbe_res_t RES_EXHAUSTED = '{
		element_value: '0,
		slot:          '0,
		ordinal:       '0,
		last:          1'b1,
		exhausted:     1'b1
	};

endpackage

>>> hdl/cmbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmbe_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/cmbe_seq.sv
// Sequencer: index vector, scan/fill stepping and result emission.
module cmbe_seq #(
	parameter int unsigned N_MAX = 64,
	parameter int unsigned R_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cmbe_pkg::cmbe_cmd_t                  cmd,
	input  logic [$clog2(N_MAX+1)-1:0]           n_eff,
	input  logic [cmbe_pkg::COUNT_R_W-1:0]       r,
	output logic                                 idle,
	output logic [$clog2(N_MAX)-1:0]             raddr,
	input  logic [cmbe_pkg::VALUE_W-1:0]         rdata,
	output cmbe_pkg::cmbe_res_t                  res,
	output logic                                 res_valid,
	input  logic                                 res_ready
);
	import cmbe_pkg::*;

	localparam int unsigned NW  = $clog2(N_MAX + 1);
	localparam int unsigned IW  = $clog2(N_MAX);
	localparam int unsigned KW  = $clog2(R_MAX + 1);
	localparam int unsigned KIW = (R_MAX > 1) ? $clog2(R_MAX) : 1;

	cmbe_state_t     state_q, state_d;
	logic [KW-1:0]   k_q;
	logic [IW-1:0]   idx_q [R_MAX];
	logic [IW-1:0]   carry_q;
	logic [NW-1:0]   base_q;
	logic            started_q;
	logic            done_q;
	logic [ORD_W-1:0] count_q;
	cmbe_res_t       res_q;
	logic            out_valid_q;

	logic [IW-1:0]   idx_rd;
	logic [NW-1:0]   limit;
	logic            bad_r;
	logic            scan_hit;
	logic            k_last;
	logic            k_zero;

	assign idx_rd   = idx_q[k_q[KIW-1:0]];
	assign limit    = base_q + NW'(k_q);
	assign scan_hit = (NW'(idx_rd) < limit);
	assign k_last   = ((8'(k_q) + 8'd1) == 8'(r));
	assign k_zero   = (k_q == '0);
	assign bad_r    = (r == '0) || (32'(r) > 32'(n_eff)) || (32'(r) > 32'(R_MAX));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd.restart && cmd.next) begin
					if (bad_r || done_q) begin
						state_d = ST_SEND;
					end else if (!started_q) begin
						state_d = ST_INIT;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_INIT: begin
				if (k_last) state_d = ST_COUNT;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = k_last ? ST_COUNT : ST_FILL;
				end else if (k_zero) begin
					state_d = ST_SEND;
				end
			end
			ST_FILL: begin
				if (k_last) state_d = ST_COUNT;
			end
			ST_COUNT: state_d = ST_READ;
			ST_READ:  state_d = ST_CAP;
			ST_CAP:   state_d = ST_SEND;
			ST_SEND: begin
				if (res_ready) begin
					state_d = res_q.last ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		idle      = (state_q == ST_IDLE);
		raddr     = idx_rd;
		res       = res_q;
		res_valid = out_valid_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			started_q   <= 1'b0;
			done_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.restart) begin
						started_q <= 1'b0;
						done_q    <= 1'b0;
						count_q   <= '0;
					end else if (cmd.next) begin
						if (bad_r || done_q) begin
							out_valid_q <= 1'b1;
						end else if (!started_q) begin
							k_q <= '0;
						end else begin
							k_q <= KW'(r - 5'd1);
						end
					end
				end
				ST_INIT: begin
					if (k_last) begin
						started_q <= 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						if (!k_last) k_q <= k_q + 1'b1;
					end else if (k_zero) begin
						done_q      <= 1'b1;
						out_valid_q <= 1'b1;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_FILL: begin
					if (!k_last) k_q <= k_q + 1'b1;
				end
				ST_COUNT: begin
					count_q <= count_q + 1'b1;
					k_q     <= '0;
				end
				ST_READ: ;
				ST_CAP: out_valid_q <= 1'b1;
				ST_SEND: begin
					if (res_ready) begin
						out_valid_q <= 1'b0;
						if (!res_q.last) k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Index vector and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd.restart && cmd.next) begin
					base_q <= n_eff - NW'(r);
					if (bad_r || done_q) res_q <= RES_EXHAUSTED;
				end
			end
			ST_INIT: idx_q[k_q[KIW-1:0]] <= IW'(k_q);
			ST_SCAN: begin
				if (scan_hit) begin
					idx_q[k_q[KIW-1:0]] <= idx_rd + 1'b1;
					carry_q             <= idx_rd + 1'b1;
				end else if (k_zero) begin
					res_q <= RES_EXHAUSTED;
				end
			end
			ST_FILL: begin
				idx_q[k_q[KIW-1:0]] <= carry_q + 1'b1;
				carry_q             <= carry_q + 1'b1;
			end
			ST_CAP: begin
				res_q.element_value <= rdata;
				res_q.slot          <= SLOT_W'(k_q);
				res_q.ordinal       <= count_q;
				res_q.last          <= k_last;
				res_q.exhausted     <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/combination_enumerator.sv
// Top level of the lexicographic combination enumerator.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  s_*     | in        | s_tvalid / s_tready     | tuser=func, tdata=position,value
//  m_*     | out       | m_tvalid / m_tready     | tdata=element_value,slot,ordinal,
//          |           |                         | tlast=last, tuser=exhausted
//  cfg_*   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A next request holds s_tready low until its run is delivered: index
// set-up on the first request after a restart, otherwise a scan plus
// refill of the index vector, then a count step and, per result, a read,
// capture and send through the element RAM's registered read port, with
// any wait while m_tready stays low. An exhausted answer goes out straight
// from idle for an unservable r or a finished run, or after a scan that
// finds no index left to step.
// arst_n clears the sequencer, counts and registers; the element RAM has no
// reset and a slot reads back only after it has been loaded.
module combination_enumerator #(
	parameter int unsigned N_MAX = 64,
	parameter int unsigned R_MAX = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [cmbe_pkg::S_DATA_W-1:0]      s_tdata,   // [5:0] position, [37:6] value
	input  logic                               s_tuser,   // [0] func
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [cmbe_pkg::M_DATA_W-1:0]      m_tdata,   // [31:0] element_value,
	                                                      // [35:32] slot, [84:36] ordinal
	output logic                               m_tlast,
	output logic                               m_tuser,   // [0] exhausted
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cmbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cmbe_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import cmbe_pkg::*;

	localparam int unsigned NW = $clog2(N_MAX + 1);
	localparam int unsigned AW = $clog2(N_MAX);

	logic [COUNT_N_W-1:0] count_n_q;
	logic [COUNT_R_W-1:0] count_r_q;
	logic [NW-1:0]        n_eff;

	logic                 s_acc;
	logic                 cfg_acc;
	logic                 load_acc;
	logic [POS_W-1:0]     position;
	logic [VALUE_W-1:0]   value;
	logic                 pos_ok;
	cmbe_cmd_t            cmd;

	logic                 seq_idle;
	logic [AW-1:0]        raddr;
	logic [VALUE_W-1:0]   rdata;
	cmbe_res_t            res;
	logic                 res_valid;

	// Unpack the input transaction.
	assign position = s_tdata[POS_W-1:0];
	assign value    = s_tdata[POS_W +: VALUE_W];

	assign s_tready  = seq_idle;
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign load_acc  = s_acc && (cmbe_func_t'(s_tuser) == FUNC_LOAD);

	// Drop loads beyond the store, but still restart.
	assign pos_ok = (32'(position) < 32'(N_MAX));

	// Any load, or a register write while the sequencer is idle, restarts the enumeration.
	assign cmd.restart = load_acc || cfg_acc;
	assign cmd.next    = s_acc && (cmbe_func_t'(s_tuser) == FUNC_NEXT);

	// Saturate n at the store depth.
	assign n_eff = (32'(count_n_q) < 32'(N_MAX)) ? NW'(count_n_q) : NW'(N_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_n_q <= '0;
			count_r_q <= '0;
		end else if (cfg_acc) begin
			unique case (cmbe_reg_t'(cfg_index))
				REG_COUNT_N: count_n_q <= cfg_data[COUNT_N_W-1:0];
				REG_COUNT_R: count_r_q <= cfg_data[COUNT_R_W-1:0];
				default: ;
			endcase
		end
	end

	// Element store.
	cmbe_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (N_MAX)
	) u_store (
		.clk   (clk),
		.we    (load_acc && pos_ok),
		.waddr (AW'(position)),
		.wdata (value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Index stepping and result emission.
	cmbe_seq #(
		.N_MAX (N_MAX),
		.R_MAX (R_MAX)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.n_eff     (n_eff),
		.r         (count_r_q),
		.idle      (seq_idle),
		.raddr     (raddr),
		.rdata     (rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (m_tready)
	);

	// Pack the result transaction; pad the top bits with zeros.
	assign m_tvalid = res_valid;
	assign m_tdata  = {3'b000, res.ordinal, res.slot, res.element_value};
	assign m_tlast  = res.last;
	assign m_tuser  = res.exhausted;

endmodule

>>> tb/tb_combination_enumerator.sv
// Self-checking testbench for combination_enumerator with a scoreboard predictor.
module tb_combination_enumerator;
	import cmbe_pkg::*;

	class combination_tracker;
		localparam int unsigned N_MAX = 64;
		localparam int unsigned R_MAX = 16;

		logic [VALUE_W-1:0]   store [N_MAX];
		int unsigned          picks [R_MAX];
		logic [ORD_W-1:0]     ordinal;
		bit                   started;
		bit                   finished;
		logic [COUNT_N_W-1:0] count_n;
		logic [COUNT_R_W-1:0] count_r;
		cmbe_res_t            pending [$];
		int unsigned          errors;
		int unsigned          loads;
		int unsigned          requests;
		int unsigned          results;
		int unsigned          exhausted_seen;

		function new();
			foreach (store[i]) store[i] = '0;
			count_n = '0;
			count_r = '0;
			errors = 0;
			loads = 0;
			requests = 0;
			results = 0;
			exhausted_seen = 0;
			rewind();
		endfunction

		function void rewind();
			foreach (picks[i]) picks[i] = 0;
			ordinal = '0;
			started = 1'b0;
			finished = 1'b0;
		endfunction

		function void write_reg(cmbe_reg_t idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_COUNT_N: count_n = data[COUNT_N_W-1:0];
				REG_COUNT_R: count_r = data[COUNT_R_W-1:0];
				default: ;
			endcase
			rewind();
		endfunction

		// Step the index vector to its lexicographic successor; 0 when none is left.
		function bit step_indices(int unsigned n, int unsigned r);
			int k;
			int j;
			for (k = int'(r) - 1; k >= 0; k--) begin
				if (picks[k] < n - r + k) begin
					picks[k]++;
					for (j = k + 1; j < int'(r); j++) picks[j] = picks[j-1] + 1;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(cmbe_func_t func, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val);
			int unsigned n;
			int unsigned r;
			int unsigned k;
			cmbe_res_t item;
			if (func == FUNC_LOAD) begin
				loads++;
				store[pos] = val;
				rewind();
				return;
			end
			requests++;
			n = (count_n < N_MAX) ? count_n : N_MAX;
			r = count_r;
			if (r == 0 || r > n || r > R_MAX || finished) begin
				pending.push_back(RES_EXHAUSTED);
				return;
			end
			if (!started) begin
				for (k = 0; k < r; k++) picks[k] = k;
				started = 1'b1;
			end else if (!step_indices(n, r)) begin
				finished = 1'b1;
				pending.push_back(RES_EXHAUSTED);
				return;
			end
			ordinal = ordinal + 1'b1;
			for (k = 0; k < r; k++) begin
				item.element_value = store[picks[k] % N_MAX];
				item.slot          = k[SLOT_W-1:0];
				item.ordinal       = ordinal;
				item.last          = (k + 1 == r);
				item.exhausted     = 1'b0;
				pending.push_back(item);
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(cmbe_res_t got);
			cmbe_res_t want;
			results++;
			if (got.exhausted === 1'b1) exhausted_seen++;
			if (pending.size() == 0) begin
				$error("result transaction with none pending: element_value 0x%0h slot %0d ordinal %0d",
					got.element_value, got.slot, got.ordinal);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("element_value", {32'b0, want.element_value},
				{32'b0, got.element_value});
			compare_field("slot", 64'(want.slot), 64'(got.slot));
			compare_field("ordinal", 64'(want.ordinal), 64'(got.ordinal));
			compare_field("last", 64'(want.last), 64'(got.last));
			compare_field("exhausted", 64'(want.exhausted), 64'(got.exhausted));
		endfunction
	endclass

	localparam int unsigned TIMEOUT_CYCLES = 600000;
	localparam int unsigned SETTLE_CYCLES  = 40;   // index stepping plus read pipeline
	localparam int unsigned RANDOM_ITEMS   = 56;
	localparam int unsigned PRELOAD_COUNT  = 32;

	// receiver stall patterns
	localparam int unsigned READY_ALWAYS = 0;
	localparam int unsigned READY_COIN   = 1;
	localparam int unsigned READY_EVERY4 = 2;
	localparam int unsigned READY_SPARSE = 3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	combination_tracker   sb;
	cmbe_res_t            seen;
	int unsigned          cycles = 0;
	int unsigned          burst_left = 0;
	int unsigned          settings = 0;
	bit                   steady = 1'b0;
	int unsigned          stall_mode = READY_ALWAYS;
	int unsigned          stall_left = 0;
	int unsigned          stall_tick = 0;

	combination_enumerator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	// Switch the receiver between stall patterns at random intervals.
	always @(posedge clk) begin
		stall_tick++;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
			READY_EVERY4: m_tready <= (stall_tick % 4 == 0);
			default:      m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Observe every transaction at the edge it completes. Check results before
	// noting a new request so a result is always matched against older work.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.element_value = m_tdata[VALUE_W-1:0];
				seen.slot          = m_tdata[VALUE_W +: SLOT_W];
				seen.ordinal       = m_tdata[VALUE_W+SLOT_W +: ORD_W];
				seen.last          = m_tlast;
				seen.exhausted     = m_tuser;
				sb.check_result(seen);
			end
			if (cfg_valid && cfg_ready)
				sb.write_reg(cmbe_reg_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready)
				sb.note_request(cmbe_func_t'(s_tuser), s_tdata[POS_W-1:0],
					s_tdata[POS_W +: VALUE_W]);
		end
	end

	// Present one input transaction and hold it until accepted. Leave tvalid
	// high so a back-to-back item needs no second assignment in this step.
	task automatic issue(input cmbe_func_t func, input logic [POS_W-1:0] pos,
		input logic [VALUE_W-1:0] val);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(S_DATA_W-POS_W-VALUE_W){1'b0}}, val, pos};
		do @(posedge clk); while (!s_tready);
	endtask

	// Count down the current burst; at its end drop tvalid for a random gap.
	task automatic sender_gap();
		int unsigned idle;
		if (steady) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 7);
		idle = $urandom_range(1, 6);
		s_tvalid <= 1'b0;
		repeat (idle) @(posedge clk);
	endtask

	task automatic load_element(input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] val);
		issue(FUNC_LOAD, pos, val);
		sender_gap();
	endtask

	// Fill the unused position and value bits with noise on a next request.
	task automatic request_next();
		issue(FUNC_NEXT, POS_W'($urandom), $urandom);
		sender_gap();
	endtask

	// Hold off until every expected result is in, then let the sequencer finish
	// any trailing index update.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back on an idle block.
	task automatic set_counts(input int unsigned n, input int unsigned r);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_COUNT_N;
		cfg_data  <= CFG_DAT_W'(n);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_COUNT_R;
		cfg_data  <= CFG_DAT_W'(r);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	initial begin
		int unsigned pos;
		int unsigned n;
		int unsigned r;
		int unsigned len;
		int unsigned made;
		logic [VALUE_W-1:0] v;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the low store positions once; no setting below walks an index
		// past position 22, so no request can read an unwritten entry. Put the
		// value extremes in the first slots.
		for (pos = 0; pos < PRELOAD_COUNT; pos++) begin
			case (pos)
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'h0000_0000;
				3: v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase
			load_element(POS_W'(pos), v);
		end

		// Directed: choice size zero, with nothing selected.
		set_counts(0, 0);
		request_next();

		// Directed: walk all six pairs of four, run off the end, ask again
		// after exhaustion, then restart through a load at the top position.
		set_counts(4, 2);
		repeat (8) request_next();
		load_element(6'd63, 32'hFFFF_FFFF);
		request_next();

		// Directed: choice larger than the element count.
		set_counts(3, 4);
		request_next();

		// Directed: count_n beyond N_MAX saturates; widest choice fills slot 15.
		set_counts(127, 16);
		repeat (2) request_next();

		// Directed: choice sizes beyond R_MAX.
		set_counts(64, 17);
		request_next();
		set_counts(64, 31);
		request_next();

		// Directed: a register write mid-enumeration restarts at ordinal 1.
		set_counts(5, 2);
		repeat (2) request_next();
		set_counts(5, 2);
		request_next();

		// Directed: single element picks, and a one-of-one enumeration.
		set_counts(64, 1);
		load_element(6'd0, 32'h8000_0000);
		repeat (2) request_next();
		set_counts(1, 1);
		repeat (2) request_next();

		// Random: mostly valid settings, each walked for 3 to 16 requests, with
		// stray loads as restarts and some unservable settings as noise.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			len = $urandom_range(4, 16);
			case ($urandom_range(0, 9))
				6: begin
					n = $urandom_range(64, 127);
					r = $urandom_range(1, 16);
					len = $urandom_range(3, 8);
				end
				7: begin
					n = $urandom_range(0, 127);
					r = 0;
				end
				8: begin
					n = $urandom_range(0, 15);
					r = $urandom_range(n + 1, 31);
				end
				9: begin
					n = $urandom_range(8, 20);
					r = $urandom_range(1, 3);
				end
				default: begin
					n = $urandom_range(1, 7);
					r = $urandom_range(1, n);
				end
			endcase
			set_counts(n, r);
			steady = ($urandom_range(0, 3) == 0);
			repeat (len) begin
				if ($urandom_range(0, 9) == 0)
					load_element(POS_W'($urandom), $urandom);
				else
					request_next();
				made++;
			end
			steady = 1'b0;
		end

		settle();
		$display("covered %0d loads and %0d next requests over %0d register settings,",
			sb.loads, sb.requests, settings);
		$display("checking %0d result transactions, %0d of them exhausted answers",
			sb.results, sb.exhausted_seen);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
